/* rtl/assert_macros.svh */
// Assertion macros used by the decompressor core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lzo_pkg.sv */
// Types and constants of the LZO1X stream decompressor.
package lzo_pkg;

  typedef enum logic [9:0] {
    PH_FIRST    = 10'b00_0000_0001,
    PH_OPCODE   = 10'b00_0000_0010,
    PH_LITLEN   = 10'b00_0000_0100,
    PH_LITERALS = 10'b00_0000_1000,
    PH_M3LEN    = 10'b00_0001_0000,
    PH_M4LEN    = 10'b00_0010_0000,
    PH_DIST_ONE = 10'b00_0100_0000,
    PH_DIST_LO  = 10'b00_1000_0000,
    PH_DIST_HI  = 10'b01_0000_0000,
    PH_MATCH    = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_FORMAT   = 3'd2,
    ST_DEPLETED = 3'd3,
    ST_BADDIST  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_PULL = 1'b1
  } func_e;

  localparam int unsigned CapWidth = 24;
  localparam logic [CapWidth-1:0] CapReset = 24'hFF_FFFF;

endpackage

/* rtl/lzo_if.sv */
// Stream channel interfaces: compressed input beats and decoded result beats.
interface lzo_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, func, in_byte, in_last, input ready);
  modport sink   (input valid, func, in_byte, in_last, output ready);
endinterface

interface lzo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       accepted;
  logic       match_pending;
  logic [2:0] status;

  modport source (output valid, out_byte, out_valid, accepted, match_pending, status,
                  input ready);
  modport sink   (input valid, out_byte, out_valid, accepted, match_pending, status,
                  output ready);
endinterface

/* rtl/lzo1x_stream_decompressor_core.sv */
// LZO1X stream decompressor: header parse, match bookkeeping and result register.
// An accepted beat's result is registered at the accepting edge and offered right after it.
// Throughput: one beat per cycle (single history RAM port pair) unless the sink stalls.
// A match byte read back-to-back at distance one is forwarded from the result register.
// Reset (rst_ni low, asynchronous) clears parse state, counts and status and sets the
// capacity to its maximum; the history RAM is not cleared, as no read reaches an unwritten entry.
`include "assert_macros.svh"

module lzo1x_stream_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = 65536,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lzo_in_if.sink       in_chan_i,
  lzo_out_if.source    out_chan_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? CntMax : s[CW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: output capacity, written on the APB access phase
  // ---------------------------------------------------------------------------
  logic [lzo_pkg::CapWidth-1:0] cap_q;
  logic                         cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
  assign pready = 1'b1;
  assign prdata = {{(32 - lzo_pkg::CapWidth){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lzo_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[lzo_pkg::CapWidth-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------------
  lzo_pkg::phase_e  phase_q, phase_d;
  lzo_pkg::status_e st_q, st_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    prod_q, prod_d;
  logic [CW-1:0]    lacc_q, lacc_d;
  logic [CW-1:0]    pend_q, pend_d;
  logic [15:0]      dist_q, dist_d;
  logic [7:0]       opc_q, opc_d;
  logic [1:0]       trail_q, trail_d;
  logic             alr_q, alr_d;
  logic             iend_q, iend_d;

  // result register
  logic          s1_valid_q;
  logic          s1_ov_q, s1_mem_q, s1_acc_q, s1_mp_q;
  logic [7:0]    s1_lit_q;
  logic [2:0]    s1_st_q;
  logic [AW-1:0] s1_waddr_q;
  logic          hit_q;
  logic [7:0]    fwd_q;
  logic [7:0]    s1_byte;
  logic [7:0]    rd_data;

  logic          fire, in_ready;
  logic          emit_ok, emit_now, use_mem, taken;
  logic [AW-1:0] src_addr;
  logic          tk_req, sm_req;
  logic [15:0]   sm_dist, d_hi;
  logic [CW-1:0] sm_len, lacc_n;
  logic [1:0]    sm_trail;
  logic [7:0]    b, x;

  assign in_ready = !s1_valid_q || out_chan_o.ready;
  assign fire     = in_chan_i.valid && in_ready;
  assign in_chan_i.ready = in_ready;

  assign b = in_chan_i.in_byte;
  assign x = opc_q;
  assign emit_ok = (33'(prod_q) < 33'(cap_q)) && (prod_q != CntMax);
  assign src_addr = wp_q - AW'(dist_q);

  always_comb begin
    phase_d  = phase_q;
    st_d     = st_q;
    wp_d     = wp_q;
    prod_d   = prod_q;
    lacc_d   = lacc_q;
    pend_d   = pend_q;
    dist_d   = dist_q;
    opc_d    = opc_q;
    trail_d  = trail_q;
    alr_d    = alr_q;
    iend_d   = iend_q;
    emit_now = 1'b0;
    use_mem  = 1'b0;
    taken    = 1'b0;
    tk_req   = 1'b0;
    sm_req   = 1'b0;
    sm_dist  = '0;
    sm_len   = '0;
    sm_trail = '0;
    lacc_n   = '0;
    d_hi     = '0;

    if (in_chan_i.func == lzo_pkg::FUNC_PULL) begin
      // pull: copy one match byte out of the history
      if (st_q == lzo_pkg::ST_RUN && phase_q == lzo_pkg::PH_MATCH) begin
        if (emit_ok) begin
          emit_now = 1'b1;
          use_mem  = 1'b1;
          pend_d   = pend_q - CW'(1);
          if (pend_q == CW'(1)) begin
            if (iend_q) begin
              st_d = lzo_pkg::ST_DEPLETED;
            end else if (trail_q != 2'd0) begin
              pend_d  = CW'(trail_q);
              phase_d = lzo_pkg::PH_LITERALS;
            end else begin
              phase_d = lzo_pkg::PH_OPCODE;
            end
          end
        end else begin
          st_d = lzo_pkg::ST_FULL;
        end
      end
    end else if (st_q == lzo_pkg::ST_RUN && phase_q != lzo_pkg::PH_MATCH) begin
      taken = 1'b1;
      case (phase_q)
        lzo_pkg::PH_FIRST: begin
          if (b > 8'd17) begin
            pend_d  = CW'(b - 8'd17);
            alr_d   = (b - 8'd17) >= 8'd4;
            trail_d = ((b - 8'd17) < 8'd4) ? 2'(b - 8'd17) : 2'd0;
            phase_d = lzo_pkg::PH_LITERALS;
          end else begin
            alr_d   = 1'b0;
            trail_d = 2'd0;
            tk_req  = 1'b1;
          end
        end
        lzo_pkg::PH_OPCODE: tk_req = 1'b1;
        lzo_pkg::PH_LITLEN, lzo_pkg::PH_M3LEN, lzo_pkg::PH_M4LEN: begin
          if (b == 8'd0) begin
            lacc_d = sat_add(lacc_q, CW'(255));
          end else begin
            if (phase_q == lzo_pkg::PH_LITLEN) begin
              lacc_n = sat_add(lacc_q, CW'(9'd15) + CW'(b));
            end else if (phase_q == lzo_pkg::PH_M3LEN) begin
              lacc_n = sat_add(lacc_q, CW'(9'd31) + CW'(b));
            end else begin
              lacc_n = sat_add(lacc_q, CW'(9'd7) + CW'(b));
            end
            lacc_d = lacc_n;
            if (phase_q == lzo_pkg::PH_LITLEN) begin
              pend_d  = sat_add(lacc_n, CW'(3));
              alr_d   = 1'b1;
              trail_d = 2'd0;
              phase_d = lzo_pkg::PH_LITERALS;
            end else begin
              phase_d = lzo_pkg::PH_DIST_LO;
            end
          end
        end
        lzo_pkg::PH_LITERALS: begin
          if (emit_ok) begin
            emit_now = 1'b1;
            pend_d   = pend_q - CW'(1);
            if (pend_q == CW'(1)) begin
              phase_d = lzo_pkg::PH_OPCODE;
            end
          end else begin
            st_d = lzo_pkg::ST_FULL;
          end
        end
        lzo_pkg::PH_DIST_ONE: begin
          sm_req   = 1'b1;
          sm_trail = x[1:0];
          if (x >= 8'd64) begin
            sm_dist = (16'(b) << 3) + 16'(x[4:2]) + 16'd1;
            sm_len  = CW'(x[7:5]) + CW'(1);
          end else if (alr_q) begin
            sm_dist = 16'd2049 + 16'(x[7:2]) + (16'(b) << 2);
            sm_len  = CW'(3);
          end else begin
            sm_dist = 16'd1 + 16'(x[7:2]) + (16'(b) << 2);
            sm_len  = CW'(2);
          end
        end
        lzo_pkg::PH_DIST_LO: begin
          dist_d  = 16'(b);
          phase_d = lzo_pkg::PH_DIST_HI;
        end
        lzo_pkg::PH_DIST_HI: begin
          if (x >= 8'd32) begin
            d_hi   = (16'(b) << 6) + 16'(dist_q[7:2]) + 16'd1;
            sm_req = 1'b1;
          end else begin
            d_hi = 16'd16384 + (16'(x[3]) << 14) + (16'(b) << 6) + 16'(dist_q[7:2]);
            if (d_hi == 16'd16384) begin
              // end marker
              st_d = (lacc_q == CW'(1)) ? lzo_pkg::ST_DONE : lzo_pkg::ST_FORMAT;
            end else begin
              sm_req = 1'b1;
            end
          end
          sm_dist  = d_hi;
          sm_len   = sat_add(lacc_q, CW'(2));
          sm_trail = dist_q[1:0];
        end
        default: ;
      endcase

      // opcode byte
      if (tk_req) begin
        opc_d  = b;
        lacc_d = '0;
        if (b >= 8'd64) begin
          phase_d = lzo_pkg::PH_DIST_ONE;
        end else if (b >= 8'd32) begin
          lacc_d  = CW'(b[4:0]);
          phase_d = (b[4:0] != 5'd0) ? lzo_pkg::PH_DIST_LO : lzo_pkg::PH_M3LEN;
        end else if (b >= 8'd16) begin
          lacc_d  = CW'(b[2:0]);
          phase_d = (b[2:0] != 3'd0) ? lzo_pkg::PH_DIST_LO : lzo_pkg::PH_M4LEN;
        end else if (alr_d || (trail_d != 2'd0)) begin
          phase_d = lzo_pkg::PH_DIST_ONE;
        end else if (b != 8'd0) begin
          pend_d  = CW'(b) + CW'(3);
          alr_d   = 1'b1;
          trail_d = 2'd0;
          phase_d = lzo_pkg::PH_LITERALS;
        end else begin
          phase_d = lzo_pkg::PH_LITLEN;
        end
      end

      // match header complete: check distance against what exists
      if (sm_req) begin
        if (CW'(sm_dist) > prod_q) begin
          st_d = lzo_pkg::ST_BADDIST;
        end else begin
          dist_d  = sm_dist;
          pend_d  = sm_len;
          trail_d = sm_trail;
          alr_d   = 1'b0;
          phase_d = lzo_pkg::PH_MATCH;
        end
      end

      // end of compressed input
      if (st_d == lzo_pkg::ST_RUN && in_chan_i.in_last) begin
        if (phase_d == lzo_pkg::PH_MATCH) begin
          iend_d = 1'b1;
        end else begin
          st_d = lzo_pkg::ST_DEPLETED;
        end
      end
    end

    if (emit_now) begin
      wp_d   = wp_q + AW'(1);
      prod_d = prod_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lzo_pkg::PH_FIRST;
      st_q    <= lzo_pkg::ST_RUN;
      wp_q    <= '0;
      prod_q  <= '0;
      lacc_q  <= '0;
      pend_q  <= '0;
      dist_q  <= '0;
      opc_q   <= '0;
      trail_q <= '0;
      alr_q   <= 1'b1;
      iend_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      st_q    <= st_d;
      wp_q    <= wp_d;
      prod_q  <= prod_d;
      lacc_q  <= lacc_d;
      pend_q  <= pend_d;
      dist_q  <= dist_d;
      opc_q   <= opc_d;
      trail_q <= trail_d;
      alr_q   <= alr_d;
      iend_q  <= iend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register; hold while the sink stalls, drop once taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (fire) begin
      s1_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_ov_q    <= emit_now;
      s1_mem_q   <= use_mem;
      s1_acc_q   <= taken;
      s1_mp_q    <= (st_d == lzo_pkg::ST_RUN) && (phase_d == lzo_pkg::PH_MATCH);
      s1_st_q    <= st_d;
      s1_lit_q   <= b;
      s1_waddr_q <= wp_q;
      // source byte is being written this very edge: forward it
      hit_q      <= s1_valid_q && s1_ov_q && (s1_waddr_q == src_addr);
      fwd_q      <= s1_byte;
    end
  end

  always_comb begin
    if (!s1_ov_q) begin
      s1_byte = 8'd0;
    end else if (s1_mem_q) begin
      s1_byte = hit_q ? fwd_q : rd_data;
    end else begin
      s1_byte = s1_lit_q;
    end
  end

  // each produced byte is written while it sits in the result register
  lzo_hist_ram #(
    .Depth (WINDOW_DEPTH),
    .AddrW (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_ov_q),
    .waddr_i (s1_waddr_q),
    .wdata_i (s1_byte),
    .re_i    (fire && use_mem),
    .raddr_i (src_addr),
    .rdata_o (rd_data)
  );

  assign out_chan_o.valid         = s1_valid_q;
  assign out_chan_o.out_byte      = s1_byte;
  assign out_chan_o.out_valid     = s1_ov_q;
  assign out_chan_o.accepted      = s1_acc_q;
  assign out_chan_o.match_pending = s1_mp_q;
  assign out_chan_o.status        = s1_st_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_push_refused_in_match,
    fire && (in_chan_i.func == lzo_pkg::FUNC_PUSH) && (phase_q == lzo_pkg::PH_MATCH),
    !s1_acc_q, "push taken while match bytes pending")
  `ASSERT_NEXT(a_wp_advances,
    fire && emit_now, wp_q == ($past(wp_q) + AW'(1)), "write position did not advance")
  `ASSERT_NEXT(a_no_byte_after_stop,
    fire && (st_q != lzo_pkg::ST_RUN), !s1_ov_q, "byte produced after decoding stopped")

endmodule

/* rtl/lzo_hist_ram.sv */
// History window RAM: one write port, one registered read port.
module lzo_hist_ram #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
